FILE: src/saai_pkg.sv
package saai_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FIELD_WIDTH = 32;
  localparam int THR_WIDTH   = 16;
  localparam int NUM_AXES    = 3;
  localparam int NUM_PAIRS   = NUM_AXES * (NUM_AXES - 1);
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;

  localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1);

  // Ordered axis pairs (a, b) for the cross-axis slab tests.
  localparam int PAIR_A [NUM_PAIRS] = '{0, 0, 1, 1, 2, 2};
  localparam int PAIR_B [NUM_PAIRS] = '{1, 2, 0, 2, 0, 1};

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] start_x;
    logic signed [FIELD_WIDTH-1:0] start_y;
    logic signed [FIELD_WIDTH-1:0] start_z;
    logic signed [FIELD_WIDTH-1:0] end_x;
    logic signed [FIELD_WIDTH-1:0] end_y;
    logic signed [FIELD_WIDTH-1:0] end_z;
    logic signed [FIELD_WIDTH-1:0] box_min_x;
    logic signed [FIELD_WIDTH-1:0] box_min_y;
    logic signed [FIELD_WIDTH-1:0] box_min_z;
    logic signed [FIELD_WIDTH-1:0] box_max_x;
    logic signed [FIELD_WIDTH-1:0] box_max_y;
    logic signed [FIELD_WIDTH-1:0] box_max_z;
  } in_item_t;

  typedef struct packed {
    logic hit;
  } out_item_t;

  // Result of one axis lane: entry/exit numerators over a positive denominator.
  typedef struct packed {
    logic                         par;
    logic                         ok;
    logic signed [DIFF_WIDTH-1:0] n_lo;
    logic signed [DIFF_WIDTH-1:0] n_hi;
    logic [COORD_WIDTH-1:0]       den;
  } axis_t;

  typedef struct packed {
    logic en_b;
    logic en_c;
  } pipe_ctrl_t;

endpackage

FILE: src/saai_if.sv
interface saai_in_if import saai_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface saai_out_if import saai_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/saai_axis_lane.sv
module saai_axis_lane import saai_pkg::*; (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [THR_WIDTH-1:0]          thr_i,
  input  logic signed [FIELD_WIDTH-1:0] start_i,
  input  logic signed [FIELD_WIDTH-1:0] end_i,
  input  logic signed [FIELD_WIDTH-1:0] bmin_i,
  input  logic signed [FIELD_WIDTH-1:0] bmax_i,
  output axis_t                         axis_o
);

  logic signed [COORD_WIDTH-1:0] s, e, bmin, bmax;
  logic signed [DIFF_WIDTH-1:0]  d, n1, n2, m1, m2;
  logic [DIFF_WIDTH-1:0]         mag;
  logic                          par, pin;
  axis_t                         axis_d, axis_q;

  always_comb begin
    s    = COORD_WIDTH'(start_i);
    e    = COORD_WIDTH'(end_i);
    bmin = COORD_WIDTH'(bmin_i);
    bmax = COORD_WIDTH'(bmax_i);
    d    = DIFF_WIDTH'(e) - DIFF_WIDTH'(s);
    n1   = DIFF_WIDTH'(bmin) - DIFF_WIDTH'(s);
    n2   = DIFF_WIDTH'(bmax) - DIFF_WIDTH'(s);
    mag  = d[DIFF_WIDTH-1] ? DIFF_WIDTH'(-d) : DIFF_WIDTH'(d);
    par  = (d == '0) || (mag < DIFF_WIDTH'(thr_i));
    pin  = (s >= bmin) && (s <= bmax);
    // A falling direction flips both numerators so the denominator is positive.
    m1   = d[DIFF_WIDTH-1] ? -n1 : n1;
    m2   = d[DIFF_WIDTH-1] ? -n2 : n2;
    axis_d.par  = par;
    axis_d.n_lo = (m1 > m2) ? m2 : m1;
    axis_d.n_hi = (m1 > m2) ? m1 : m2;
    axis_d.den  = mag[COORD_WIDTH-1:0];
    // Checks against the initial interval [0,1] need no multiply.
    axis_d.ok   = par ? pin
                      : ((axis_d.n_lo <= $signed(mag)) && (axis_d.n_hi >= 0));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      axis_q <= axis_d;
    end
  end

  assign axis_o = axis_q;

endmodule

FILE: src/saai_merge.sv
module saai_merge import saai_pkg::*; (
  input  logic       clk_i,
  input  pipe_ctrl_t ctrl_i,
  input  axis_t      axis_i [NUM_AXES],
  output logic       hit_o
);

  logic [PROD_WIDTH-1:0] pl_q [NUM_PAIRS];
  logic [PROD_WIDTH-1:0] pr_q [NUM_PAIRS];
  logic [NUM_PAIRS-1:0]  nl_q, nr_q, skip_q;
  logic [NUM_AXES-1:0]   ok_q;
  logic [NUM_PAIRS-1:0]  pair_ok;
  logic signed [PROD_WIDTH:0] lv [NUM_PAIRS];
  logic signed [PROD_WIDTH:0] rv [NUM_PAIRS];
  logic                  hit_q;

  function automatic logic [COORD_WIDTH-1:0] mag_of(logic signed [DIFF_WIDTH-1:0] v);
    logic [DIFF_WIDTH-1:0] m;
    m = v[DIFF_WIDTH-1] ? DIFF_WIDTH'(-v) : DIFF_WIDTH'(v);
    return m[COORD_WIDTH-1:0];
  endfunction

  // Stage B: entry of axis a against exit of axis b, cross multiplied.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_b) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
        pl_q[p]   <= PROD_WIDTH'(mag_of(axis_i[PAIR_A[p]].n_lo))
                     * PROD_WIDTH'(axis_i[PAIR_B[p]].den);
        pr_q[p]   <= PROD_WIDTH'(mag_of(axis_i[PAIR_B[p]].n_hi))
                     * PROD_WIDTH'(axis_i[PAIR_A[p]].den);
        nl_q[p]   <= axis_i[PAIR_A[p]].n_lo[DIFF_WIDTH-1];
        nr_q[p]   <= axis_i[PAIR_B[p]].n_hi[DIFF_WIDTH-1];
        skip_q[p] <= axis_i[PAIR_A[p]].par || axis_i[PAIR_B[p]].par;
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        ok_q[a] <= axis_i[a].ok;
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PAIRS; p++) begin
      lv[p] = nl_q[p] ? -$signed({1'b0, pl_q[p]}) : $signed({1'b0, pl_q[p]});
      rv[p] = nr_q[p] ? -$signed({1'b0, pr_q[p]}) : $signed({1'b0, pr_q[p]});
      pair_ok[p] = skip_q[p] || (lv[p] <= rv[p]);
    end
  end

  // Stage C: the interval stays non-empty only if every entry precedes every exit.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_c) begin
      hit_q <= (&ok_q) && (&pair_ok);
    end
  end

  assign hit_o = hit_q;

endmodule

FILE: src/segment_aabb_intersect_core.sv
// Segment versus axis-aligned box test by the slab method, exact rational
// compares. Three axis lanes form entry/exit numerators, a merge stage cross
// multiplies every entry against every other axis's exit with six pairs of
// 32x32 multipliers, and a final compare sets the hit flag. An accepted beat
// passes the lane, multiply and output registers; one beat is taken every
// cycle while the output side keeps up. parallel_threshold resets to 1.
module segment_aabb_intersect_core import saai_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [THR_WIDTH-1:0] cfg_wdata_i,
  saai_in_if.sink              in_i,
  saai_out_if.source           out_o
);

  logic [THR_WIDTH-1:0] thr_q;
  logic                 v1_q, v2_q, v3_q;
  logic                 en1, en2, en3;
  pipe_ctrl_t           ctrl;
  axis_t                axis [NUM_AXES];
  logic                 hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign en3 = !v3_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign ctrl.en_b = en2;
  assign ctrl.en_c = en3;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  saai_axis_lane u_lane_x (
    .clk_i, .en_i(en1), .thr_i(thr_q),
    .start_i(in_i.data.start_x), .end_i(in_i.data.end_x),
    .bmin_i(in_i.data.box_min_x), .bmax_i(in_i.data.box_max_x), .axis_o(axis[0])
  );
  saai_axis_lane u_lane_y (
    .clk_i, .en_i(en1), .thr_i(thr_q),
    .start_i(in_i.data.start_y), .end_i(in_i.data.end_y),
    .bmin_i(in_i.data.box_min_y), .bmax_i(in_i.data.box_max_y), .axis_o(axis[1])
  );
  saai_axis_lane u_lane_z (
    .clk_i, .en_i(en1), .thr_i(thr_q),
    .start_i(in_i.data.start_z), .end_i(in_i.data.end_z),
    .bmin_i(in_i.data.box_min_z), .bmax_i(in_i.data.box_max_z), .axis_o(axis[2])
  );

  saai_merge u_merge (
    .clk_i, .ctrl_i(ctrl), .axis_i(axis), .hit_o(hit)
  );

  assign out_o.valid    = v3_q;
  assign out_o.data.hit = hit;

  a_fill1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted beat did not enter the lane stage");
  a_fill2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && en2) |=> v2_q)
    else $error("lane result lost before the multiply stage");
  a_fill3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && en3) |=> v3_q)
    else $error("multiply result lost before the output stage");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en2) |=> v2_q)
    else $error("stalled multiply stage dropped its beat");

endmodule

FILE: test/tb.sv
module tb import saai_pkg::*; ();

  localparam int LAT_CYCLES   = 3;
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [THR_WIDTH-1:0] cfg_wdata_i = '0;

  saai_in_if  in_ch ();
  saai_out_if out_ch ();

  segment_aabb_intersect_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_item_t  pending_boxes[$];
  out_item_t expected_hits[$];
  logic [THR_WIDTH-1:0] threshold_model = THR_RESET;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  bit  sender_pause = 1'b0;
  bit  hold_out = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic add_box(input in_item_t it);
    pending_boxes = {pending_boxes, it};
  endtask

  // Sign of a/b - c/d with b, d positive, exact.
  function automatic int cmp_ratio(input logic signed [63:0] a, input logic signed [63:0] b,
                                   input logic signed [63:0] c, input logic signed [63:0] d);
    logic signed [127:0] p;
    logic signed [127:0] q;
    p = 128'(a) * 128'(d);
    q = 128'(c) * 128'(b);
    if (p > q) return 1;
    if (p < q) return -1;
    return 0;
  endfunction

  function automatic out_item_t predict_hit(input in_item_t it);
    logic signed [63:0] s, e, bmin, bmax, dir, n1, n2, tmp, mag;
    logic signed [63:0] lo_n, lo_d, hi_n, hi_d;
    logic signed [31:0] sv[3], ev[3], mnv[3], mxv[3];
    out_item_t r;
    r.hit = 1'b1;
    lo_n = 0; lo_d = 1; hi_n = 1; hi_d = 1;
    sv = '{it.start_x, it.start_y, it.start_z};
    ev = '{it.end_x, it.end_y, it.end_z};
    mnv = '{it.box_min_x, it.box_min_y, it.box_min_z};
    mxv = '{it.box_max_x, it.box_max_y, it.box_max_z};
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      s = 64'(sv[ax]); e = 64'(ev[ax]);
      bmin = 64'(mnv[ax]); bmax = 64'(mxv[ax]);
      dir = e - s;
      mag = (dir < 0) ? -dir : dir;
      if (dir == 0 || mag < 64'(threshold_model)) begin
        if (s < bmin || s > bmax) r.hit = 1'b0;
      end else begin
        n1 = bmin - s;
        n2 = bmax - s;
        if (dir < 0) begin
          dir = -dir; n1 = -n1; n2 = -n2;
        end
        if (n1 > n2) begin
          tmp = n1; n1 = n2; n2 = tmp;
        end
        if (cmp_ratio(n1, dir, lo_n, lo_d) > 0) begin
          lo_n = n1; lo_d = dir;
        end
        if (cmp_ratio(n2, dir, hi_n, hi_d) < 0) begin
          hi_n = n2; hi_d = dir;
        end
      end
    end
    if (cmp_ratio(lo_n, lo_d, hi_n, hi_d) > 0) r.hit = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord(input int span);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  // Mostly segments aimed near a box so both hit and miss answers occur.
  function automatic in_item_t make_random_box();
    in_item_t it;
    logic [31:0] c[12];
    int span;
    span = ($urandom_range(0, 3) == 0) ? 32'h7FFF_0000 : 32'h0004_0000;
    foreach (c[i]) c[i] = rand_coord(span);
    if ($urandom_range(0, 3) != 0) begin
      for (int a = 0; a < 3; a++) begin
        if ($signed(c[6 + a]) > $signed(c[9 + a]) && $urandom_range(0, 5) != 0) begin
          c[6 + a] = c[9 + a];
          c[9 + a] = rand_coord(span);
          if ($signed(c[9 + a]) < $signed(c[6 + a])) c[9 + a] = c[6 + a];
        end
      end
    end
    if ($urandom_range(0, 7) == 0) c[3 + $urandom_range(0, 2)] = c[$urandom_range(0, 2)];
    if ($urandom_range(0, 9) == 0) for (int a = 0; a < 3; a++) c[3 + a] = c[a];
    if ($urandom_range(0, 5) == 0) c[4] = c[1] + 32'($urandom_range(0, 3)) - 32'd1;
    it = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
    return it;
  endfunction

  function automatic in_item_t make_box(input int sx, sy, sz, ex, ey, ez,
                                        mnx, mny, mnz, mxx, mxy, mxz);
    in_item_t it;
    it = {sx, sy, sz, ex, ey, ez, mnx, mny, mnz, mxx, mxy, mxz};
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_boxes.size() != 0 || expected_hits.size() != 0) @(posedge clk_i);
    repeat (LAT_CYCLES + 2) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_WIDTH-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    threshold_model = v;
    @(posedge clk_i);
  endtask

  task automatic queue_random(input int n);
    repeat (n) add_box(make_random_box());
  endtask

  // Driver: predictions are made when a beat is accepted. The beat on offer stays at the
  // head of the queue until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      send_gap    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_hits = {expected_hits, predict_hit(in_ch.data)};
        void'(pending_boxes.pop_front());
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 3);
          in_ch.valid <= 1'b0;
        end else if (!sender_pause && pending_boxes.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_boxes[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= 0;
    end else if (hold_out) begin
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      recv_gap <= $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        if (out_ch.data.hit !== expected_hits[0].hit)
          report_mismatch($sformatf("hit got %b expected %b",
                                    out_ch.data.hit, expected_hits[0].hit));
        void'(expected_hits.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unit box, hits, misses, touching faces, degenerate and inverted boxes.
    add_box(make_box(-65536, 0, 0, 65536, 0, 0,
                     -32768, -32768, -32768, 32768, 32768, 32768));
    add_box(make_box(-65536, 65536, 0, 65536, 65536, 0,
                     -32768, -32768, -32768, 32768, 32768, 32768));
    add_box(make_box(-65536, 0, 0, -32768, 0, 0,
                     -32768, -32768, -32768, 32768, 32768, 32768));
    add_box(make_box(-65536, 0, 0, -32769, 0, 0,
                     -32768, -32768, -32768, 32768, 32768, 32768));
    add_box(make_box(0, 0, 0, 0, 0, 0,
                     -1, -1, -1, 1, 1, 1));
    add_box(make_box(5, 0, 0, 5, 0, 0,
                     -1, -1, -1, 1, 1, 1));
    add_box(make_box(0, 0, 0, 0, 0, 0,
                     1, -1, -1, -1, 1, 1));
    add_box(make_box(-100, 0, 0, 100, 0, 0,
                     10, -1, -1, -10, 1, 1));
    add_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_box(make_box(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0,
                     -1, -1, -1, 1, 1, 1));
    add_box(make_box(-10, -10, -10, 10, 10, 10,
                     9, 9, -20, 20, 20, -9));
    add_box(make_box(-10, -10, 0, 10, 10, 0,
                     9, -20, -1, 20, -9, 1));
    add_box(make_box(0, 0, 0, 1, 0, 0,
                     0, 0, 0, 0, 0, 0));
    wait_drained();

    // Larger threshold: near-zero directions become parallel.
    write_threshold(16'hFFFF);
    add_box(make_box(5, 0, 0, 6, 0, 0, -1, -1, -1, 1, 1, 1));
    add_box(make_box(0, 0, 0, 65534, 0, 0, -1, -1, -1, 1, 1, 1));
    add_box(make_box(0, 0, 0, 65535, 0, 0, 10, -1, -1, 20, 1, 1));
    queue_random(150);
    wait_drained();

    write_threshold(16'h0000);
    add_box(make_box(0, 0, 0, 0, 0, 0, -1, -1, -1, 1, 1, 1));
    add_box(make_box(3, 0, 0, 3, 5, 0, -1, -1, -1, 1, 10, 1));
    queue_random(150);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering.
    write_threshold(16'h0100);
    queue_random(60);
    hold_out = 1'b1;
    repeat (40) @(posedge clk_i);
    hold_out = 1'b0;
    queue_random(140);
    // Sender pause until all results have come back.
    sender_pause = 1'b1;
    while (expected_hits.size() != 0 || (in_ch.valid && !in_ch.ready)) @(posedge clk_i);
    sender_pause = 1'b0;
    wait_drained();

    write_threshold(16'h0001);
    queue_random(RANDOM_ITEMS - 500);
    while (pending_boxes.size() > 150) @(posedge clk_i);
    calm = 1'b1;
    wait_drained();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
